// ===== src/markup_unit_tokenizer_macros.svh =====
// Assertion macros for the markup unit tokenizer.
// Assumes the module has clk and arst_n in scope; no other dependencies.
`ifndef MARKUP_UNIT_TOKENIZER_MACROS_SVH
`define MARKUP_UNIT_TOKENIZER_MACROS_SVH
`ifndef SYNTHESIS
`define MUT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MUT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define MUT_ASSERT(lbl, prop, msg)
`define MUT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== src/mut_pkg.sv =====
// Shared types and widths for the markup unit tokenizer.
// No dependencies.
package mut_pkg;

	localparam int unsigned TOK_START_W = 16;
	localparam int unsigned TOK_END_W   = 17;
	localparam int unsigned APB_DATA_W  = 32;
	localparam int unsigned APB_ADDR_W  = 3;

	// register word index
	localparam logic REG_SCRIPT_MODE = 1'b0;

	typedef struct packed {
		logic [TOK_START_W-1:0] token_start;
		logic [TOK_END_W-1:0]   token_end;
		logic                   run_last;
	} tok_t;

	// up to two tokens produced by one byte, packed toward t0
	typedef struct packed {
		logic v0;
		logic v1;
		tok_t t0;
		tok_t t1;
	} tok_pair_t;

endpackage

// ===== src/mut_byte_if.sv =====
// Input channel of the tokenizer: one text byte per word.
// Depends on nothing.
interface mut_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source(output valid, text_byte, end_of_text, input ready);
	modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

// ===== src/mut_tok_if.sv =====
// Output channel of the tokenizer: one token offset pair per word.
// Depends on nothing.
interface mut_tok_if;
	logic        valid;
	logic        ready;
	logic [15:0] token_start;
	logic [16:0] token_end;
	logic        run_last;

	modport source(output valid, token_start, token_end, run_last, input ready);
	modport sink(input valid, token_start, token_end, run_last, output ready);
endinterface

// ===== src/mut_cfg.sv =====
// APB register file of the tokenizer: holds the script_mode bit.
// Depends on mut_pkg.
module mut_cfg import mut_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic                  script_mode
);

	logic script_mode_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_SCRIPT_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			script_mode_q <= 1'b0;
		end else if (wr_en) begin
			script_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SCRIPT_MODE) begin
			prdata[0] = script_mode_q;
		end
	end

	assign script_mode = script_mode_q;

endmodule

// ===== src/mut_core.sv =====
// Lexer step: input byte register, scan state and the per-byte token decision.
// Depends on mut_pkg and mut_byte_if.
module mut_core import mut_pkg::*; #(
	parameter int unsigned MAX_TEXT_LEN = 65536
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         script_mode,
	input  logic         room,
	mut_byte_if.sink     byte_in,
	output tok_pair_t    push
);

	localparam int unsigned OFF_W = $clog2(MAX_TEXT_LEN);
	localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(MAX_TEXT_LEN - 1);

	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RUN,
		PH_TAG,
		PH_BRACE,
		PH_DASH,
		PH_SEL
	} phase_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_run_start(input logic [7:0] c);
		return is_alpha(c) || (c == CH_UNDER) || (c == CH_AT);
	endfunction

	function automatic logic is_run_part(input logic [7:0] c);
		return is_alpha(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDER) ||
			(c == CH_DASH);
	endfunction

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eot_s1;

	phase_t           phase_q, phase_n;
	logic [OFF_W-1:0] start_q, start_n;
	logic [OFF_W-1:0] off_q, off_n;
	logic             pcb_q, pcb_n;

	logic             fire, last;
	logic [OFF_W:0]   off_x, off_p1, st_p1;
	logic             bt_space, bt_tag, bt_run, bt_pend, bt_emit;
	phase_t           bt_phase;
	logic             e0_v, call_bt, b_emit;
	logic [OFF_W:0]   e0_end;
	tok_t             e0_tok, bt_tok;

	assign fire          = valid_s1 && room;
	assign byte_in.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.text_byte;
			eot_s1  <= byte_in.end_of_text;
		end
	end

	assign last   = eot_s1 || (off_q >= LAST_OFF);
	assign off_x  = {1'b0, off_q};
	assign off_p1 = {1'b0, off_q} + {{OFF_W{1'b0}}, 1'b1};
	assign st_p1  = {1'b0, start_q} + {{OFF_W{1'b0}}, 1'b1};

	// classification of the byte when it opens a fresh token
	always_comb begin
		bt_space = is_space(byte_s1);
		bt_tag   = !script_mode && (byte_s1 == CH_LBRACK);
		bt_run   = is_run_start(byte_s1);
		bt_pend  = script_mode && !last && ((byte_s1 == CH_LBRACE) || (byte_s1 == CH_DASH));
		bt_emit  = !bt_space && ((bt_tag || bt_run) ? last : !bt_pend);
		if (bt_space) begin
			bt_phase = PH_IDLE;
		end else if (bt_tag) begin
			bt_phase = last ? PH_IDLE : PH_TAG;
		end else if (bt_run) begin
			bt_phase = last ? PH_IDLE : PH_RUN;
		end else if (bt_pend) begin
			bt_phase = (byte_s1 == CH_LBRACE) ? PH_BRACE : PH_DASH;
		end else begin
			bt_phase = PH_IDLE;
		end
	end

	always_comb begin
		e0_v    = 1'b0;
		e0_end  = off_p1;
		call_bt = 1'b0;
		phase_n = phase_q;
		pcb_n   = pcb_q;
		unique case (phase_q)
			PH_RUN: begin
				if (is_run_part(byte_s1)) begin
					e0_v = last;
				end else begin
					e0_v    = 1'b1;
					e0_end  = off_x;
					call_bt = 1'b1;
				end
			end
			PH_TAG: begin
				if ((byte_s1 == CH_RBRACK) || last) begin
					e0_v    = 1'b1;
					phase_n = PH_IDLE;
				end
			end
			PH_BRACE: begin
				if (byte_s1 == CH_LBRACE) begin
					if (last) begin
						e0_v    = 1'b1;
						phase_n = PH_IDLE;
					end else begin
						phase_n = PH_SEL;
						pcb_n   = 1'b0;
					end
				end else begin
					e0_v    = 1'b1;
					e0_end  = st_p1;
					call_bt = 1'b1;
				end
			end
			PH_DASH: begin
				if (byte_s1 == CH_GT) begin
					e0_v    = 1'b1;
					phase_n = PH_IDLE;
				end else begin
					e0_v    = 1'b1;
					e0_end  = st_p1;
					call_bt = 1'b1;
				end
			end
			PH_SEL: begin
				if (pcb_q && (byte_s1 == CH_RBRACE)) begin
					e0_v    = 1'b1;
					phase_n = PH_IDLE;
					pcb_n   = 1'b0;
				end else if (last) begin
					// unclosed selector: token stops before the final byte
					e0_v    = 1'b1;
					e0_end  = off_x;
					call_bt = 1'b1;
				end else begin
					pcb_n = (byte_s1 == CH_RBRACE);
				end
			end
			default: begin
				call_bt = 1'b1;
			end
		endcase

		if (call_bt) begin
			phase_n = bt_phase;
		end
		start_n = (call_bt && !bt_space) ? off_q : start_q;
		if (last) begin
			phase_n = PH_IDLE;
			pcb_n   = 1'b0;
			off_n   = '0;
		end else begin
			off_n   = off_p1[OFF_W-1:0];
		end
	end

	assign b_emit = call_bt && bt_emit;

	always_comb begin
		e0_tok.token_start = TOK_START_W'(start_q);
		e0_tok.token_end   = TOK_END_W'(e0_end);
		e0_tok.run_last    = !b_emit;
		bt_tok.token_start = TOK_START_W'(off_q);
		bt_tok.token_end   = TOK_END_W'(off_p1);
		bt_tok.run_last    = 1'b1;
		push.v0 = fire && (e0_v || b_emit);
		push.v1 = fire && e0_v && b_emit;
		push.t0 = e0_v ? e0_tok : bt_tok;
		push.t1 = bt_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			start_q <= '0;
			off_q   <= '0;
			pcb_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			start_q <= start_n;
			off_q   <= off_n;
			pcb_q   <= pcb_n;
		end
	end

endmodule

// ===== src/mut_outq.sv =====
// Four-word token queue: up to two tokens in a cycle, one out a cycle on ready.
// Depends on mut_pkg, mut_tok_if and the assertion macro header.
`include "markup_unit_tokenizer_macros.svh"
module mut_outq import mut_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tok_pair_t push,
	output logic      room,
	mut_tok_if.source tok_out
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	tok_t          mem [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pushn;
	logic          pop;
	tok_t          head;

	assign pushn = CW'(push.v0) + CW'(push.v1);
	assign pop   = tok_out.valid && tok_out.ready;
	// room for a full pair, from registered state only
	assign room  = cnt_q <= CW'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem[wp_q] <= push.t0;
		end
		if (push.v1) begin
			mem[wp_q + AW'(1)] <= push.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + AW'(pushn);
			rp_q  <= rp_q + AW'(pop);
			cnt_q <= cnt_q + pushn - CW'(pop);
		end
	end

	assign head                = mem[rp_q];
	assign tok_out.valid       = cnt_q != '0;
	assign tok_out.token_start = head.token_start;
	assign tok_out.token_end   = head.token_end;
	assign tok_out.run_last    = head.run_last;

	`MUT_ASSERT(a_push_has_room, push.v0 |-> room, "token pushed without room")
	`MUT_ASSERT(a_pair_packed, push.v1 |-> push.v0, "second token pushed without first")
	`MUT_NEVER(a_cnt_bound, cnt_q > CW'(DEPTH), "queue count past depth")
	`MUT_ASSERT(a_cnt_track, 1'b1 |=> (cnt_q == CW'($past(cnt_q) + $past(pushn) - $past(CW'(pop)))), "queue count mismatch")

endmodule

// ===== src/markup_unit_tokenizer.sv =====
// Markup unit tokenizer: turns a byte stream into token offset pairs.
// Channels: byte_in (sink) takes one text byte per word with end_of_text set
//   on the final byte; tok_out (source) gives token_start / token_end words,
//   run_last set on the last token caused by a byte. Both are valid/ready.
// APB port: register 0 (script_mode, bit 0) at byte address 0; write only
//   while no byte is in flight. pready is tied high.
// Path: an accepted byte is held in the input byte register, scanned from there
//   once the queue has room, and its tokens enter the queue and leave on tok_out.
// Throughput: one byte per cycle while the queue has room; a byte can yield two
//   tokens, and tok_out drains one word per cycle while tok_out.ready is high.
// Stall: tokens collect in a four-word queue; byte_in.ready drops once a byte is
//   held and fewer than two free words remain, from registered state only.
// Reset: arst_n clears scan state, offset and queue; script_mode returns to
//   block mode. Offsets restart at zero after each end of text, and the byte
//   at offset MAX_TEXT_LEN-1 closes the text by itself.
module markup_unit_tokenizer import mut_pkg::*; #(
	parameter int unsigned MAX_TEXT_LEN = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	mut_byte_if.sink              byte_in,
	mut_tok_if.source             tok_out
);

	logic      script_mode;
	logic      room;
	tok_pair_t push;

	mut_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.script_mode (script_mode)
	);

	mut_core #(
		.MAX_TEXT_LEN (MAX_TEXT_LEN)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.script_mode (script_mode),
		.room        (room),
		.byte_in     (byte_in),
		.push        (push)
	);

	mut_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.tok_out (tok_out)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for markup_unit_tokenizer: directed probe table, then random texts.
// Needs mut_pkg, mut_byte_if, mut_tok_if and the tokenizer RTL.
module tb_top;
	import mut_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int TEXT_LIMIT    = 65536;
	localparam int RAND_ITEMS    = 1200;
	localparam int SETTLE_CYCLES = 4;
	localparam int NUM_PROBES    = 32;

	localparam logic [APB_ADDR_W-1:0] MODE_ADDR = APB_ADDR_W'({REG_SCRIPT_MODE, 2'b00});

	localparam logic [7:0] CH_LBRACK = "[";
	localparam logic [7:0] CH_RBRACK = "]";
	localparam logic [7:0] CH_LBRACE = "{";
	localparam logic [7:0] CH_RBRACE = "}";
	localparam logic [7:0] CH_DASH   = "-";
	localparam logic [7:0] CH_GT     = ">";
	localparam logic [7:0] CH_AT     = "@";
	localparam logic [7:0] CH_UNDER  = "_";
	localparam logic [7:0] CH_SPACE  = " ";

	// probe table columns
	localparam logic FIN = 1'b1, MORE = 1'b0;
	localparam logic BLK = 1'b0, SCR = 1'b1;
	localparam logic TYPED = 1'b1, MODEL = 1'b0;

	typedef enum logic [2:0] {
		LEX_IDLE, LEX_RUN, LEX_TAG, LEX_BRACE, LEX_DASH, LEX_SEL
	} lex_phase_t;

	typedef struct packed {
		logic [7:0]  chr;
		logic        fin;
		logic        script;
		logic        typed;
		logic [1:0]  n_tok;
		logic [15:0] s0;
		logic [16:0] e0;
	} probe_t;

	localparam probe_t PROBES [NUM_PROBES] = '{
		'{"A",       FIN,  BLK, TYPED, 2'd1, 16'd0, 17'd1},
		'{CH_SPACE,  FIN,  BLK, TYPED, 2'd0, 16'd0, 17'd0},
		'{8'hFF,     FIN,  BLK, TYPED, 2'd1, 16'd0, 17'd1},
		'{8'h00,     FIN,  BLK, TYPED, 2'd1, 16'd0, 17'd1},
		'{CH_LBRACK, MORE, BLK, TYPED, 2'd0, 16'd0, 17'd0},
		'{CH_RBRACK, MORE, BLK, TYPED, 2'd1, 16'd0, 17'd2},
		'{CH_AT,     MORE, BLK, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_DASH,   MORE, BLK, MODEL, 2'd0, 16'd0, 17'd0},
		'{"+",       FIN,  BLK, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_LBRACK, MORE, BLK, MODEL, 2'd0, 16'd0, 17'd0},
		'{"z",       FIN,  BLK, TYPED, 2'd1, 16'd0, 17'd2},
		'{CH_LBRACK, MORE, BLK, MODEL, 2'd0, 16'd0, 17'd0},
		// mode flips while the tag is open; the tag still closes on ']'
		'{CH_RBRACK, MORE, SCR, TYPED, 2'd1, 16'd0, 17'd2},
		'{CH_LBRACE, MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_LBRACE, MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_RBRACE, MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_RBRACE, MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_DASH,   MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_GT,     MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{"q",       MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_DASH,   MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_GT,     MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_LBRACE, MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_DASH,   MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{"7",       MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_LBRACE, MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_LBRACE, MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_RBRACE, FIN,  SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_DASH,   FIN,  SCR, TYPED, 2'd1, 16'd0, 17'd1},
		'{CH_LBRACE, MORE, SCR, MODEL, 2'd0, 16'd0, 17'd0},
		'{CH_LBRACE, FIN,  SCR, TYPED, 2'd1, 16'd0, 17'd2},
		'{CH_LBRACE, FIN,  SCR, TYPED, 2'd1, 16'd0, 17'd1}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	mut_byte_if text_ch();
	mut_tok_if  token_ch();

	markup_unit_tokenizer #(.MAX_TEXT_LEN(TEXT_LIMIT)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.byte_in(text_ch),
		.tok_out(token_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// lexer state mirrored from the spec
	logic        mode_script = 1'b0;
	lex_phase_t  lex_phase = LEX_IDLE;
	logic [15:0] open_start = '0;
	logic [16:0] text_off = '0;
	logic        saw_close = 1'b0;
	tok_t        step_tok [2];
	int          step_cnt;

	tok_t        tokens_due [$];
	logic [7:0]  text_buf [$];

	int mismatches = 0;
	int bytes_sent = 0;
	int tokens_seen = 0;
	int texts_sent = 0;
	int mode_writes = 0;
	int burst_left = 0;

	function automatic void due_add(input tok_t t);
		tokens_due.insert(tokens_due.size(), t);
	endfunction

	function automatic void text_add(input logic [7:0] b);
		text_buf.insert(text_buf.size(), b);
	endfunction

	function automatic bit is_blank(input logic [7:0] b);
		return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic bit is_letter(input logic [7:0] b);
		return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
	endfunction

	function automatic bit run_head(input logic [7:0] b);
		return is_letter(b) || b == CH_UNDER || b == CH_AT;
	endfunction

	function automatic bit run_body(input logic [7:0] b);
		return is_letter(b) || (b >= "0" && b <= "9") || b == CH_UNDER || b == CH_DASH;
	endfunction

	function automatic void emit_tok(input logic [16:0] s, input logic [16:0] e);
		if (step_cnt < 2) begin
			step_tok[step_cnt].token_start = s[15:0];
			step_tok[step_cnt].token_end = e;
			step_tok[step_cnt].run_last = 1'b0;
			step_cnt++;
		end
	endfunction

	// byte b at offset off starts a fresh token (whitespace is dropped)
	function automatic void open_tok(input logic [7:0] b, input logic [16:0] off, input bit fin);
		lex_phase = LEX_IDLE;
		if (is_blank(b))
			return;
		open_start = off[15:0];
		if (!mode_script && b == CH_LBRACK) begin
			if (fin)
				emit_tok(off, off + 17'd1);
			else
				lex_phase = LEX_TAG;
		end else if (run_head(b)) begin
			if (fin)
				emit_tok(off, off + 17'd1);
			else
				lex_phase = LEX_RUN;
		end else if (mode_script && !fin && (b == CH_LBRACE || b == CH_DASH)) begin
			lex_phase = (b == CH_LBRACE) ? LEX_BRACE : LEX_DASH;
		end else begin
			emit_tok(off, off + 17'd1);
		end
	endfunction

	function automatic void lex_byte(input logic [7:0] b, input logic eot);
		logic [16:0] off;
		logic [16:0] st;
		bit fin;
		off = text_off;
		st = {1'b0, open_start};
		fin = eot || (off >= TEXT_LIMIT - 1);
		step_cnt = 0;
		case (lex_phase)
			LEX_RUN: begin
				if (run_body(b)) begin
					if (fin) begin
						emit_tok(st, off + 17'd1);
						lex_phase = LEX_IDLE;
					end
				end else begin
					emit_tok(st, off);
					open_tok(b, off, fin);
				end
			end
			LEX_TAG: begin
				if (b == CH_RBRACK || fin) begin
					emit_tok(st, off + 17'd1);
					lex_phase = LEX_IDLE;
				end
			end
			LEX_BRACE: begin
				if (b == CH_LBRACE) begin
					if (fin) begin
						emit_tok(st, off + 17'd1);
						lex_phase = LEX_IDLE;
					end else begin
						lex_phase = LEX_SEL;
						saw_close = 1'b0;
					end
				end else begin
					emit_tok(st, st + 17'd1);
					open_tok(b, off, fin);
				end
			end
			LEX_DASH: begin
				if (b == CH_GT) begin
					emit_tok(st, off + 17'd1);
					lex_phase = LEX_IDLE;
				end else begin
					emit_tok(st, st + 17'd1);
					open_tok(b, off, fin);
				end
			end
			LEX_SEL: begin
				if (saw_close && b == CH_RBRACE) begin
					emit_tok(st, off + 17'd1);
					lex_phase = LEX_IDLE;
					saw_close = 1'b0;
				end else if (fin) begin
					// unclosed selector: body ends before the final byte
					emit_tok(st, off);
					open_tok(b, off, fin);
				end else begin
					saw_close = (b == CH_RBRACE);
				end
			end
			default: open_tok(b, off, fin);
		endcase
		if (fin) begin
			lex_phase = LEX_IDLE;
			text_off = '0;
			saw_close = 1'b0;
		end else begin
			text_off = off + 17'd1;
		end
		if (step_cnt > 0)
			step_tok[step_cnt - 1].run_last = 1'b1;
	endfunction

	// drive one word, wait for the handshake, then predict its tokens
	task automatic send_byte(input logic [7:0] b, input logic eot, input bit take_model);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(100, 300);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
			if (gap > 0) begin
				text_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.end_of_text <= eot;
		do @(posedge clk); while (text_ch.ready !== 1'b1);
		bytes_sent++;
		lex_byte(b, eot);
		if (take_model)
			for (int k = 0; k < step_cnt; k++)
				due_add(step_tok[k]);
	endtask

	task automatic settle();
		text_ch.valid <= 1'b0;
		while (tokens_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MODE_ADDR;
		pwdata <= {31'($urandom()), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mode_script = v;
		mode_writes++;
	endtask

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(0, 1) != 0) ? 8'("A" + $urandom_range(0, 25))
		                                   : 8'("a" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_body();
		case ($urandom_range(0, 3))
			0: return rand_letter();
			1: return 8'("0" + $urandom_range(0, 9));
			2: return CH_UNDER;
			default: return CH_DASH;
		endcase
	endfunction

	// append one lexical piece for the current mode; a few are left unclosed
	function automatic void add_piece();
		logic [7:0] c;
		logic [7:0] punct [9];
		punct = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_DASH, CH_GT, CH_AT,
		          CH_UNDER, "+"};
		case ($urandom_range(0, 5))
			0: repeat ($urandom_range(1, 3)) begin
				c = 8'($urandom_range(0, 5));
				text_add((c == 8'd5) ? CH_SPACE : 8'h09 + c);
			end
			1: begin
				case ($urandom_range(0, 2))
					0: text_add(CH_AT);
					1: text_add(CH_UNDER);
					default: text_add(rand_letter());
				endcase
				repeat ($urandom_range(0, 6)) text_add(rand_body());
			end
			2: begin
				if (mode_script) begin
					text_add(CH_LBRACE);
					text_add(CH_LBRACE);
					repeat ($urandom_range(0, 4)) text_add(8'($urandom()));
					if ($urandom_range(0, 5) != 0) begin
						text_add(CH_RBRACE);
						text_add(CH_RBRACE);
					end
				end else begin
					text_add(CH_LBRACK);
					repeat ($urandom_range(0, 5)) begin
						c = 8'($urandom());
						text_add((c == CH_RBRACK) ? CH_LBRACK : c);
					end
					if ($urandom_range(0, 5) != 0)
						text_add(CH_RBRACK);
				end
			end
			3: begin
				text_add(CH_DASH);
				if ($urandom_range(0, 3) != 0)
					text_add(CH_GT);
			end
			4: text_add(8'($urandom()));
			default: text_add(punct[$urandom_range(0, 8)]);
		endcase
	endfunction

	task automatic send_text();
		bit open_end;
		int last;
		text_buf.delete();
		if ($urandom_range(0, 4) == 0) begin
			// noise: raw bytes, end flags anywhere
			repeat ($urandom_range(1, 12)) text_add(8'($urandom()));
			foreach (text_buf[k])
				send_byte(text_buf[k], $urandom_range(0, 5) == 0, 1'b1);
		end else begin
			open_end = ($urandom_range(0, 15) == 0);
			repeat ($urandom_range(1, 10)) add_piece();
			last = text_buf.size() - 1;
			foreach (text_buf[k])
				send_byte(text_buf[k], (k == last) && !open_end, 1'b1);
		end
		texts_sent++;
	endtask

	// receiver: switches between stall styles every so often
	initial begin
		int style;
		int left;
		int tick;
		style = 0;
		left = 0;
		tick = 0;
		token_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				style = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			tick++;
			case (style)
				0: token_ch.ready <= 1'b1;
				1: token_ch.ready <= 1'($urandom_range(0, 1));
				2: token_ch.ready <= (tick % 4) != 0;
				default: token_ch.ready <= (tick % 20) < 10;
			endcase
		end
	end

	always @(posedge clk) begin
		tok_t want;
		if (arst_n && token_ch.valid === 1'b1 && token_ch.ready === 1'b1) begin
			if (tokens_due.size() == 0) begin
				$display("%0t: unexpected token start=%0d end=%0d last=%0b", $time,
				         token_ch.token_start, token_ch.token_end, token_ch.run_last);
				mismatches++;
			end else begin
				want = tokens_due.pop_front();
				tokens_seen++;
				if (token_ch.token_start !== want.token_start ||
				    token_ch.token_end !== want.token_end ||
				    token_ch.run_last !== want.run_last) begin
					$display("%0t: exp %0d..%0d last=%0b, got %0d..%0d last=%0b",
					         $time, want.token_start, want.token_end, want.run_last,
					         token_ch.token_start, token_ch.token_end, token_ch.run_last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#40ms;
		$display("%0t: timeout, %0d tokens still due", $time, tokens_due.size());
		$display("status: fail");
		$finish;
	end

	initial begin
		int rand_base;
		int phase;
		text_ch.valid <= 1'b0;
		text_ch.text_byte <= '0;
		text_ch.end_of_text <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_PROBES; i++) begin
			if (PROBES[i].script != mode_script) begin
				settle();
				write_mode(PROBES[i].script);
			end
			send_byte(PROBES[i].chr, PROBES[i].fin, !PROBES[i].typed);
			if (PROBES[i].typed && PROBES[i].n_tok != 0)
				due_add('{PROBES[i].s0, PROBES[i].e0, 1'b1});
		end

		rand_base = bytes_sent;
		phase = 0;
		while (bytes_sent - rand_base < RAND_ITEMS) begin
			settle();
			write_mode((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
			repeat ($urandom_range(3, 12)) send_text();
			phase++;
		end

		settle();
		$display("sent %0d bytes in %0d texts over %0d mode writes (block and script mode)",
		         bytes_sent, texts_sent, mode_writes);
		$display("checked %0d tokens from directed probes and random texts under stalls",
		         tokens_seen);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
